/* hdl/bounded_ordered_list_engine_core_defines.svh */
// Assertion macros used by the list engine datapath.
`ifndef BOUNDED_ORDERED_LIST_ENGINE_CORE_DEFINES_SVH
`define BOUNDED_ORDERED_LIST_ENGINE_CORE_DEFINES_SVH
// a holds in a cycle -> b holds in the same cycle
`define BOLE_ASSERT_IMP(lbl, clk, rst, a, b) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
      else $error("implication check failed");
// a holds in a cycle -> b holds in the next cycle
`define BOLE_ASSERT_NXT(lbl, clk, rst, a, b) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
      else $error("next-cycle check failed");
`endif

/* hdl/bole_pkg.sv */
// Types and codes shared by the list engine controller and datapath.
package bole_pkg;
   localparam int KeyW = 32;

   typedef enum logic [3:0] {
      OP_INS_FRONT  = 4'd0,
      OP_INS_BACK   = 4'd1,
      OP_INS_SORTED = 4'd2,
      OP_DEL_FRONT  = 4'd3,
      OP_DEL_BACK   = 4'd4,
      OP_DEL_KEY    = 4'd5,
      OP_REVERSE    = 4'd6,
      OP_CLEAR      = 4'd7,
      OP_DUMP       = 4'd8
   } op_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_EMPTY    = 2'd1,
      ST_NOTFOUND = 2'd2,
      ST_FULL     = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE, S_DECODE, S_READ, S_STEP, S_FINISH
   } state_type;

   typedef struct packed {
      logic load;
      logic simple;
      logic rd;
      logic step;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic scan;
      logic out_free;
      logic done;
      logic is_dump;
   } stat_type;
endpackage

/* hdl/bounded_ordered_list_engine_core.sv */
// Top level of the bounded ordered list engine.
// Simple command: decoded, then the response word is registered once the output is free;
// the next request is taken when the controller is back in idle. Sorted insert, key delete
// and dump walk the store through one registered read port, a read and a step state per
// entry (dump walks at most 16 entries); output stalls hold dump steps and the final word.
// Synchronous active-high reset empties the list; the key store itself is not cleared.
module bounded_ordered_list_engine_core #(
   parameter int CAPACITY = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,  // op[3:0], key[35:4], zero pad
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,  // status[1:0], key_out[33:2], index_out[37:34], count[42:38]
   output logic        rsp_tlast
);
   import bole_pkg::*;

   cmd_type  cmd;
   stat_type st;
   logic [1:0]  status;
   logic [31:0] key_out;
   logic [3:0]  index_out;
   logic [4:0]  count;

   bole_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .st         (st),
      .cmd        (cmd)
   );

   bole_dp #(
      .CAPACITY (CAPACITY)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .st         (st),
      .req_op     (req_tdata[3:0]),
      .req_key    (req_tdata[35:4]),
      .rsp_tready (rsp_tready),
      .rsp_valid  (rsp_tvalid),
      .rsp_status (status),
      .rsp_key    (key_out),
      .rsp_index  (index_out),
      .rsp_count  (count),
      .rsp_last   (rsp_tlast)
   );

   assign rsp_tdata = {5'b0, count, index_out, key_out, status};
endmodule

/* hdl/bole_ctrl.sv */
// Command sequencer for the list engine.
module bole_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  bole_pkg::stat_type st,
   output bole_pkg::cmd_type  cmd
);
   import bole_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            if (st.scan) begin
               state_in = S_READ;
            end else if (st.out_free) begin
               cmd.simple = 1'b1;
               state_in   = S_IDLE;
            end
         end
         S_READ: begin
            cmd.rd   = 1'b1;
            state_in = S_STEP;
         end
         S_STEP: begin
            if (!st.is_dump || st.out_free) begin
               cmd.step = 1'b1;
               if (st.done) begin
                  state_in = st.is_dump ? S_IDLE : S_FINISH;
               end else begin
                  state_in = S_READ;
               end
            end
         end
         S_FINISH: begin
            if (st.out_free) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end
endmodule

/* hdl/bole_dp.sv */
// Datapath: circular key store, front pointer and direction, scan and result word.
`include "bounded_ordered_list_engine_core_defines.svh"
module bole_dp #(
   parameter int CAPACITY = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  bole_pkg::cmd_type  cmd,
   output bole_pkg::stat_type st,
   input  logic [3:0]         req_op,
   input  logic [31:0]        req_key,
   input  logic               rsp_tready,
   output logic               rsp_valid,
   output logic [1:0]         rsp_status,
   output logic [31:0]        rsp_key,
   output logic [3:0]         rsp_index,
   output logic [4:0]         rsp_count,
   output logic               rsp_last
);
   import bole_pkg::*;

   localparam int PW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);

   function automatic logic [PW-1:0] stp(input logic [PW-1:0] base,
                                         input logic [PW-1:0] off,
                                         input logic back);
      logic [PW:0] s;
      logic [PW:0] cap;
      cap = (PW+1)'(CAPACITY);
      if (back) begin
         if (base >= off) begin
            s = {1'b0, base} - {1'b0, off};
         end else begin
            s = {1'b0, base} + cap - {1'b0, off};
         end
      end else begin
         s = {1'b0, base} + {1'b0, off};
         if (s >= cap) begin
            s = s - cap;
         end
      end
      return s[PW-1:0];
   endfunction

   logic [KeyW-1:0] mem [CAPACITY];
   logic [KeyW-1:0] rdata_ff;

   op_type          op_ff;
   logic [KeyW-1:0] key_ff, carry_ff, carry_in;
   logic [CW-1:0]   cnt_ff, cnt_in, j_ff, j_in;
   logic [PW-1:0]   fr_ff, fr_in;
   logic            dr_ff, dr_in, found_ff, found_in, started_ff, started_in;

   logic            rsp_valid_ff, rsp_valid_in, emit;
   status_type      sts_ff, sts_in;
   logic [KeyW-1:0] rkey_ff, rkey_in;
   logic [3:0]      ridx_ff, ridx_in;
   logic [4:0]      rcnt_ff;
   logic            rlast_ff, rlast_in;

   logic            we;
   logic [PW-1:0]   wa;
   logic [KeyW-1:0] wd;
   logic [PW-1:0]   phys_j, phys_jm1;
   logic            full, empty, out_free, ins;

   assign full     = (cnt_ff == CW'(CAPACITY));
   assign empty    = (cnt_ff == '0);
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign phys_j   = stp(fr_ff, PW'(j_ff), dr_ff);
   assign phys_jm1 = stp(fr_ff, PW'(j_ff - 1'b1), dr_ff);
   assign ins      = started_ff || (j_ff == cnt_ff) ||
                     ($signed(rdata_ff) >= $signed(key_ff));

   always_comb begin
      st.out_free = out_free;
      st.is_dump  = (op_ff == OP_DUMP);
      st.scan     = ((op_ff == OP_INS_SORTED) && !full) ||
                    (((op_ff == OP_DEL_KEY) || (op_ff == OP_DUMP)) && !empty);
      case (op_ff)
         OP_INS_SORTED: st.done = (j_ff == cnt_ff);
         OP_DEL_KEY:    st.done = (j_ff == cnt_ff - 1'b1);
         default:       st.done = (j_ff == cnt_ff - 1'b1) || (9'(j_ff) == 9'd15);
      endcase
   end

   always_comb begin
      cnt_in       = cnt_ff;
      fr_in        = fr_ff;
      dr_in        = dr_ff;
      j_in         = j_ff;
      carry_in     = carry_ff;
      found_in     = found_ff;
      started_in   = started_ff;
      we           = 1'b0;
      wa           = phys_j;
      wd           = carry_ff;
      emit         = 1'b0;
      sts_in       = ST_OK;
      rkey_in      = '0;
      ridx_in      = '0;
      rlast_in     = 1'b1;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;

      if (cmd.simple) begin
         emit = 1'b1;
         case (op_ff)
            OP_INS_FRONT, OP_INS_BACK, OP_INS_SORTED: begin
               if (full) begin
                  sts_in = ST_FULL;
               end else begin
                  we     = 1'b1;
                  wd     = key_ff;
                  cnt_in = cnt_ff + 1'b1;
                  if (op_ff == OP_INS_FRONT) begin
                     fr_in = stp(fr_ff, PW'(1), !dr_ff);
                     wa    = fr_in;
                  end else begin
                     wa = stp(fr_ff, PW'(cnt_ff), dr_ff);
                  end
               end
            end
            OP_DEL_FRONT, OP_DEL_BACK, OP_DEL_KEY: begin
               if (empty) begin
                  sts_in = ST_EMPTY;
               end else begin
                  cnt_in = cnt_ff - 1'b1;
                  if (op_ff == OP_DEL_FRONT) begin
                     fr_in = stp(fr_ff, PW'(1), dr_ff);
                  end
               end
            end
            OP_REVERSE: begin
               if (empty) begin
                  sts_in = ST_EMPTY;
               end else begin
                  fr_in = stp(fr_ff, PW'(cnt_ff - 1'b1), dr_ff);
                  dr_in = !dr_ff;
               end
            end
            OP_CLEAR: cnt_in = '0;
            OP_DUMP:  sts_in = ST_EMPTY;
            default:  sts_in = ST_OK;
         endcase
      end

      if (cmd.step) begin
         j_in = j_ff + 1'b1;
         case (op_ff)
            OP_INS_SORTED: begin
               if (ins) begin
                  we         = 1'b1;
                  wa         = phys_j;
                  wd         = carry_ff;
                  carry_in   = rdata_ff;
                  started_in = 1'b1;
               end
            end
            OP_DEL_KEY: begin
               if (found_ff) begin
                  we = 1'b1;
                  wa = phys_jm1;
                  wd = rdata_ff;
               end else if (rdata_ff == key_ff) begin
                  found_in = 1'b1;
               end
            end
            default: begin
               emit     = 1'b1;
               rkey_in  = rdata_ff;
               ridx_in  = 4'(j_ff);
               rlast_in = st.done;
            end
         endcase
      end

      if (cmd.finish) begin
         emit = 1'b1;
         if (op_ff == OP_INS_SORTED) begin
            cnt_in = cnt_ff + 1'b1;
         end else if (found_ff) begin
            cnt_in = cnt_ff - 1'b1;
         end else begin
            sts_in = ST_NOTFOUND;
         end
      end

      if (emit) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem[wa] <= wd;
      end
      if (cmd.rd) begin
         rdata_ff <= mem[phys_j];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         fr_ff        <= '0;
         dr_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
         j_ff         <= '0;
         found_ff     <= 1'b0;
         started_ff   <= 1'b0;
         op_ff        <= OP_CLEAR;
      end else begin
         cnt_ff       <= cnt_in;
         fr_ff        <= fr_in;
         dr_ff        <= dr_in;
         rsp_valid_ff <= rsp_valid_in;
         if (cmd.load) begin
            op_ff      <= op_type'(req_op);
            j_ff       <= '0;
            found_ff   <= 1'b0;
            started_ff <= 1'b0;
         end else begin
            j_ff       <= j_in;
            found_ff   <= found_in;
            started_ff <= started_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         key_ff   <= req_key;
         carry_ff <= req_key;
      end else begin
         carry_ff <= carry_in;
      end
      if (emit) begin
         sts_ff   <= sts_in;
         rkey_ff  <= rkey_in;
         ridx_ff  <= ridx_in;
         rcnt_ff  <= 5'(cnt_in);
         rlast_ff <= rlast_in;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = sts_ff;
   assign rsp_key    = rkey_ff;
   assign rsp_index  = ridx_ff;
   assign rsp_count  = rcnt_ff;
   assign rsp_last   = rlast_ff;

   `BOLE_ASSERT_IMP(a_cnt_bound, clock, reset, 1'b1, cnt_ff <= CW'(CAPACITY))
   `BOLE_ASSERT_IMP(a_emit_free, clock, reset, emit, out_free)
   `BOLE_ASSERT_NXT(a_load_init, clock, reset, cmd.load, j_ff == '0 && !found_ff && !started_ff)
endmodule

/* tb/bounded_ordered_list_engine_core_test.sv */
// Self-checking testbench for the list engine: directed table, then random commands.
`timescale 1ns / 1ps
module bounded_ordered_list_engine_core_test;
   import bole_pkg::*;

   localparam int Capacity = 16;
   localparam int MaxWords = 16;
   localparam int WatchLimit = 20000;
   localparam int RandomCount = 480;
   localparam logic [3:0] OpUnused = 4'd11;

   typedef struct {
      logic [1:0]  status;
      logic [31:0] key_out;
      logic [3:0]  index_out;
      logic [4:0]  count;
      logic        last;
   } rsp_word_type;

   typedef struct {
      logic [3:0]  op;
      logic [31:0] key;
      logic        typed;
      logic [1:0]  status;
      logic [4:0]  count;
   } cmd_row_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [39:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [47:0] rsp_tdata;
   logic        rsp_tlast;

   logic [31:0]  list_keys [Capacity];
   int           list_len;
   rsp_word_type pending_words [$];
   cmd_row_type  plan [$];
   int           errors;
   int           watch;
   int           stall_left;
   bit           quiet;

   bounded_ordered_list_engine_core #(.CAPACITY(Capacity)) u_top (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic rsp_word_type make_word(logic [1:0] st, logic [31:0] k, logic [3:0] idx,
                                              logic last);
      rsp_word_type w;
      w.status = st;
      w.key_out = k;
      w.index_out = idx;
      w.count = 5'(list_len);
      w.last = last;
      return w;
   endfunction

   task automatic list_insert(int pos, logic [31:0] k);
      for (int i = list_len; i > pos; i--) list_keys[i] = list_keys[i-1];
      list_keys[pos] = k;
      list_len++;
   endtask

   task automatic list_remove(int pos);
      for (int i = pos; i + 1 < list_len; i++) list_keys[i] = list_keys[i+1];
      list_len--;
   endtask

   task automatic predict_list_cmd(logic [3:0] op, logic [31:0] k);
      logic [1:0] st;
      logic [31:0] t;
      int i;
      int n;
      st = ST_OK;
      case (op)
         OP_INS_FRONT, OP_INS_BACK, OP_INS_SORTED: begin
            if (list_len >= Capacity) st = ST_FULL;
            else if (op == OP_INS_FRONT) list_insert(0, k);
            else if (op == OP_INS_BACK) list_insert(list_len, k);
            else begin
               for (i = 0; i < list_len; i++)
                  if ($signed(list_keys[i]) >= $signed(k)) break;
               list_insert(i, k);
            end
         end
         OP_DEL_FRONT, OP_DEL_BACK, OP_DEL_KEY: begin
            if (list_len == 0) st = ST_EMPTY;
            else if (op == OP_DEL_FRONT) list_remove(0);
            else if (op == OP_DEL_BACK) list_len--;
            else begin
               for (i = 0; i < list_len; i++)
                  if (list_keys[i] == k) break;
               if (i < list_len) list_remove(i);
               else st = ST_NOTFOUND;
            end
         end
         OP_REVERSE: begin
            if (list_len == 0) st = ST_EMPTY;
            else
               for (i = 0; i < list_len / 2; i++) begin
                  t = list_keys[i];
                  list_keys[i] = list_keys[list_len-1-i];
                  list_keys[list_len-1-i] = t;
               end
         end
         OP_CLEAR: list_len = 0;
         OP_DUMP: begin
            if (list_len == 0) st = ST_EMPTY;
            else begin
               n = list_len < MaxWords ? list_len : MaxWords;
               for (i = 0; i < n; i++)
                  pending_words.push_back(make_word(ST_OK, list_keys[i], 4'(i), i + 1 == n));
               return;
            end
         end
         default: ;
      endcase
      pending_words.push_back(make_word(st, '0, '0, 1'b1));
   endtask

   task automatic add_row(logic [3:0] op, logic [31:0] k, logic typed = 1'b0,
                          logic [1:0] st = ST_OK, logic [4:0] cnt = '0);
      cmd_row_type r;
      r.op = op;
      r.key = k;
      r.typed = typed;
      r.status = st;
      r.count = cnt;
      plan.push_back(r);
   endtask

   task automatic idle_gap();
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
   endtask

   task automatic send_cmd(cmd_row_type r);
      idle_gap();
      req_tvalid <= 1'b1;
      req_tdata <= {4'b0, r.key, r.op};
      do @(posedge clock); while (!req_tready);
      predict_list_cmd(r.op, r.key);
      if (r.typed) begin
         if (pending_words[$].status !== r.status || pending_words[$].count !== r.count) begin
            $display("%0t: table row op %0d expected status %0d count %0d, predicted %0d %0d",
                     $time, r.op, r.status, r.count, pending_words[$].status,
                     pending_words[$].count);
            errors++;
         end
      end
   endtask

   function automatic logic [31:0] pick_key();
      case ($urandom_range(0, 5))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return list_len > 0 ? list_keys[$urandom_range(0, list_len - 1)] : $urandom;
         3, 4: return 32'($signed($urandom_range(0, 40)) - 20);
         default: return $urandom;
      endcase
   endfunction

   // response check
   always @(posedge clock) begin
      rsp_word_type exp_w;
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (pending_words.size() == 0) begin
               $display("%0t: unexpected word %h last %b", $time, rsp_tdata, rsp_tlast);
               errors++;
            end else begin
               exp_w = pending_words.pop_front();
               if (rsp_tdata[1:0] !== exp_w.status || rsp_tdata[33:2] !== exp_w.key_out ||
                   rsp_tdata[37:34] !== exp_w.index_out || rsp_tdata[42:38] !== exp_w.count ||
                   rsp_tlast !== exp_w.last) begin
                  $display("%0t: expected st %0d key %h idx %0d cnt %0d last %b", $time,
                           exp_w.status, exp_w.key_out, exp_w.index_out, exp_w.count,
                           exp_w.last);
                  $display("%0t:   actual st %0d key %h idx %0d cnt %0d last %b", $time,
                           rsp_tdata[1:0], rsp_tdata[33:2], rsp_tdata[37:34],
                           rsp_tdata[42:38], rsp_tlast);
                  errors++;
               end
            end
         end
         if (quiet || stall_left == 1) begin
            rsp_tready <= 1'b1;
            stall_left <= 0;
         end else if (stall_left > 1) begin
            stall_left <= stall_left - 1;
         end else if ($urandom_range(0, 4) == 0) begin
            rsp_tready <= 1'b0;
            stall_left <= $urandom_range(1, 7);
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // watchdog on idle cycles
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) watch <= 0;
      else watch <= watch + 1;
      if (watch >= WatchLimit) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   initial begin
      int k;
      cmd_row_type r;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      errors = 0;
      quiet = 1'b0;
      list_len = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      add_row(OP_DUMP, '0, 1'b1, ST_EMPTY, 5'd0);
      add_row(OP_DEL_FRONT, '0, 1'b1, ST_EMPTY, 5'd0);
      add_row(OP_DEL_BACK, '0, 1'b1, ST_EMPTY, 5'd0);
      add_row(OP_DEL_KEY, 32'd5, 1'b1, ST_EMPTY, 5'd0);
      add_row(OP_REVERSE, '0, 1'b1, ST_EMPTY, 5'd0);
      add_row(OP_INS_SORTED, 32'h7fff_ffff, 1'b1, ST_OK, 5'd1);
      add_row(OP_INS_SORTED, 32'h8000_0000, 1'b1, ST_OK, 5'd2);
      add_row(OP_INS_SORTED, 32'hffff_ffff);
      add_row(OP_INS_FRONT, 32'd0);
      add_row(OP_INS_BACK, 32'hffff_ffff);
      add_row(OP_DEL_KEY, 32'h1234_5678, 1'b1, ST_NOTFOUND, 5'd5);
      add_row(OP_DEL_KEY, 32'hffff_ffff);
      add_row(OP_REVERSE, '0);
      add_row(OP_DUMP, '0);
      add_row(OpUnused, 32'hffff_ffff, 1'b1, ST_OK, 5'd4);
      add_row(4'd15, '0, 1'b1, ST_OK, 5'd4);
      for (int i = 0; i < 12; i++) add_row(OP_INS_SORTED, 32'(i * 7 - 30));
      add_row(OP_INS_BACK, 32'd1, 1'b1, ST_FULL, 5'd16);
      add_row(OP_DUMP, '0);
      add_row(OP_DEL_FRONT, '0);
      add_row(OP_DEL_BACK, '0);
      add_row(OP_CLEAR, '0, 1'b1, ST_OK, 5'd0);
      foreach (plan[i]) send_cmd(plan[i]);

      req_tvalid <= 1'b0;
      wait (pending_words.size() == 0);
      @(posedge clock);

      for (int n = 0; n < RandomCount; n++) begin
         if (n == RandomCount * 7 / 8) quiet = 1'b1;
         k = $urandom_range(0, 99);
         if (k < 30) r.op = 4'($urandom_range(0, 2));
         else if (k < 50) r.op = 4'($urandom_range(3, 5));
         else if (k < 58) r.op = OP_REVERSE;
         else if (k < 61) r.op = OP_CLEAR;
         else if (k < 75) r.op = OP_DUMP;
         else if (k < 78) r.op = 4'($urandom_range(9, 15));
         else r.op = list_len > 8 ? OP_DEL_KEY : OP_INS_SORTED;
         r.key = pick_key();
         r.typed = 1'b0;
         send_cmd(r);
         if (n == RandomCount / 2) begin
            req_tvalid <= 1'b0;
            wait (pending_words.size() == 0);
            @(posedge clock);
         end
      end
      req_tvalid <= 1'b0;
      wait (pending_words.size() == 0);
      repeat (50) @(posedge clock);
      if (errors == 0) $display("TEST PASSED");
      else $display("TEST FAILED");
      $finish;
   end
endmodule

/* sim.f */
+incdir+hdl
hdl/bole_pkg.sv
hdl/bole_ctrl.sv
hdl/bole_dp.sv
hdl/bounded_ordered_list_engine_core.sv
tb/bounded_ordered_list_engine_core_test.sv
